>>> rtl/mrfb_pkg.sv
// ----------------------------------------------------------------------------
// mrfb_pkg
// Types, constants and the crc helper shared by the frame builder modules.
// ----------------------------------------------------------------------------
package mrfb_pkg;

    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned FRAME_BYTES  = 8;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    // byte positions of the frame
    localparam logic [2:0] IDX_HDR_LAST = 3'd5;
    localparam logic [2:0] IDX_CRC_LO   = 3'd6;
    localparam logic [2:0] IDX_CRC_HI   = 3'd7;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] second_word;
    } t_req;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_result;

    // header bytes, element 0 goes out first
    typedef logic [HEADER_BYTES-1:0][7:0] t_hdr;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/mrfb_front.sv
// ----------------------------------------------------------------------------
// mrfb_front
// Accepts requests into a two-entry queue and presents the head as frame
// header bytes to the serializer.
// ----------------------------------------------------------------------------
module mrfb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mrfb_pkg::t_req  i_req,
    output logic            o_busy,
    input  logic            i_pop,
    output logic            o_valid,
    output mrfb_pkg::t_hdr  o_hdr
);
    import mrfb_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_req       head;

    assign o_busy  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign head = r_mem[r_rd_ptr];

    always_comb begin
        o_hdr[0] = head.device_address;
        o_hdr[1] = head.function_code;
        o_hdr[2] = head.register_address[15:8];
        o_hdr[3] = head.register_address[7:0];
        o_hdr[4] = head.second_word[15:8];
        o_hdr[5] = head.second_word[7:0];
    end

endmodule

>>> rtl/mrfb_back.sv
// ----------------------------------------------------------------------------
// mrfb_back
// Serializes one frame a byte per cycle, folding each header byte into the
// crc and appending the crc low byte then high byte.
// ----------------------------------------------------------------------------
module mrfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mrfb_pkg::t_hdr    i_hdr,
    output logic              o_pop,
    output logic              o_strobe,
    output mrfb_pkg::t_result o_result
);
    import mrfb_pkg::*;

    logic        r_active, n_active;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    t_hdr        r_hdr, n_hdr;
    logic        r_strobe, n_strobe;
    t_result     r_result, n_result;
    logic [7:0]  cur_byte;

    always_comb begin
        case (r_cnt)
            IDX_CRC_LO: cur_byte = r_crc[7:0];
            IDX_CRC_HI: cur_byte = r_crc[15:8];
            default:    cur_byte = r_hdr[r_cnt];
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_hdr    = r_hdr;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        if (r_active) begin
            n_strobe            = 1'b1;
            n_result.frame_byte = cur_byte;
            n_result.last_byte  = (r_cnt == IDX_CRC_HI);
            n_cnt               = r_cnt + 3'd1;
            if (r_cnt <= IDX_HDR_LAST) begin
                n_crc = crc_add_byte(r_crc, cur_byte);
            end
        end
        // load the next frame when idle or while the last byte goes out
        if ((!r_active || r_cnt == IDX_CRC_HI) && i_valid) begin
            o_pop    = 1'b1;
            n_active = 1'b1;
            n_cnt    = 3'd0;
            n_crc    = CRC_SEED;
            n_hdr    = i_hdr;
        end else if (r_active && r_cnt == IDX_CRC_HI) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
        r_crc    <= n_crc;
        r_hdr    <= n_hdr;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTH
    // a frame goes out without gaps until its last byte
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_result.last_byte |=> r_strobe)
        else $error("gap inside a frame");

    // the last flag comes only on the crc high byte position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_strobe && n_result.last_byte |-> r_cnt == IDX_CRC_HI)
        else $error("last flag at wrong position");

    // a frame in progress is never dropped before its last byte
    a_stay_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && r_cnt != IDX_CRC_HI |=> r_active && r_cnt == $past(r_cnt) + 3'd1)
        else $error("frame aborted");

    // the queue is popped only at a frame boundary
    a_pop_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid && (!r_active || r_cnt == IDX_CRC_HI))
        else $error("pop in mid frame");
`endif

endmodule

>>> rtl/modbus_rtu_frame_builder_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_builder_core
// Builds an eight-byte Modbus RTU request frame with crc-16/modbus trailer.
// ----------------------------------------------------------------------------
// Each item accepted on i_start (while o_busy is low) becomes eight bytes on
// o_result, one per cycle on consecutive cycles, each marked by o_strobe for
// exactly one cycle: address, function, register address high and low, second
// word high and low, crc low, crc high (flagged by last_byte). The receiver
// cannot stall and must take every byte in its strobe cycle. With the
// serializer idle an accepted item passes from the queue to the serializer and
// its first byte is then registered onto o_result; otherwise the item waits in
// the queue until the current frame's last byte goes out. A two-item queue sits
// in front of the serializer; back to back frames follow without gaps on the
// byte-wide output. o_busy is high while the queue is full.
module modbus_rtu_frame_builder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mrfb_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_strobe,
    output mrfb_pkg::t_result o_result
);
    import mrfb_pkg::*;

    logic pop;
    logic q_valid;
    t_hdr q_hdr;

    mrfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_hdr   (q_hdr)
    );

    mrfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_hdr    (q_hdr),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

>>> verif/modbus_rtu_frame_builder_core_tb.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_builder_core_tb
// Self-checking bench for the Modbus RTU request frame builder.
// ----------------------------------------------------------------------------
// Requests go in on the start/busy handshake with random gaps. Every accepted
// request is turned into its eight expected frame bytes, with a bitwise
// crc-16/modbus, and queued. Each strobed byte is then checked, field by
// field, against the oldest queued byte. Directed requests cover the field
// extremes and common function codes. A back to back run and a drain pause
// follow, then a long random run.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_builder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfb_pkg::*;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_req    i_req   = '0;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;

    t_result frame_q[$];
    int      fail_count   = 0;
    int      req_count    = 0;
    int      direct_count = 0;
    int      bytes_seen   = 0;
    bit      no_idle      = 1'b0;

    modbus_rtu_frame_builder_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // expected frame of one request: six header bytes then crc low, crc high
    function automatic void predict_frame(input t_req r);
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        t_result     res;
        frame[0] = r.device_address;
        frame[1] = r.function_code;
        frame[2] = r.register_address[15:8];
        frame[3] = r.register_address[7:0];
        frame[4] = r.second_word[15:8];
        frame[5] = r.second_word[7:0];
        crc = CRC_SEED;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            crc = crc ^ {8'h00, frame[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            res.frame_byte = frame[i];
            res.last_byte  = (i == FRAME_BYTES - 1);
            frame_q.insert(frame_q.size(), res);
        end
    endfunction

    function automatic t_req make_req(input logic [7:0] addr, input logic [7:0] fc,
                                      input logic [15:0] reg_addr,
                                      input logic [15:0] word);
        t_req r;
        r.device_address   = addr;
        r.function_code    = fc;
        r.register_address = reg_addr;
        r.second_word      = word;
        return r;
    endfunction

    // mostly random, with the usual read/write codes and corner words mixed in
    function automatic t_req random_req();
        t_req r;
        r.device_address   = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom);
        r.function_code    = ($urandom_range(2) == 0) ? 8'($urandom_range(1, 6))
                                                      : 8'($urandom);
        r.register_address = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
        r.second_word      = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
        return r;
    endfunction

    task automatic send_req(input t_req r);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        predict_frame(r);
        req_count++;
    endtask

    // each cycle idles with the same chance, so gaps are of random length
    task automatic maybe_idle();
        while (!no_idle && $urandom_range(99) < 37) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_frames();
        i_start <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        t_req list [$];
        list = {make_req(8'h00, 8'h00, 16'h0000, 16'h0000),
                make_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                make_req(8'hFF, 8'h00, 16'hFFFF, 16'h0000),
                make_req(8'h00, 8'hFF, 16'h0000, 16'hFFFF),
                make_req(8'h80, 8'h01, 16'h8000, 16'h0001),
                make_req(8'h01, 8'h80, 16'h0001, 16'h8000),
                make_req(8'hAA, 8'h55, 16'hAAAA, 16'h5555),
                make_req(8'h55, 8'hAA, 16'h5555, 16'hAAAA)};
        foreach (list[i]) begin
            maybe_idle();
            send_req(list[i]);
        end
        direct_count += list.size();
    endtask

    task automatic test_function_codes();
        t_req list [$];
        // first one is the textbook read of ten holding registers
        list = {make_req(8'h01, 8'h03, 16'h0000, 16'h000A),
                make_req(8'h11, 8'h01, 16'h0013, 16'h0025),
                make_req(8'h11, 8'h02, 16'h00C4, 16'h0016),
                make_req(8'h11, 8'h04, 16'h0008, 16'h0001),
                make_req(8'h11, 8'h05, 16'h00AC, 16'hFF00),
                make_req(8'h11, 8'h06, 16'h0001, 16'h0003),
                make_req(8'hF7, 8'h10, 16'h1234, 16'h0002)};
        foreach (list[i]) begin
            maybe_idle();
            send_req(list[i]);
        end
        direct_count += list.size();
    endtask

    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        repeat (n) send_req(random_req());
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause(input int n);
        repeat (n) begin
            maybe_idle();
            send_req(random_req());
        end
        drain_frames();
        repeat (n) begin
            maybe_idle();
            send_req(random_req());
        end
    endtask

    task automatic test_random(input int n);
        repeat (n) begin
            maybe_idle();
            send_req(random_req());
        end
    endtask

    // the receiver cannot stall, so every strobe is one item to check
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_strobe) begin
            bytes_seen++;
            if (frame_q.size() == 0) begin
                $error("unexpected byte %02h last_byte %0b",
                       o_result.frame_byte, o_result.last_byte);
                fail_count++;
            end else begin
                exp_res = frame_q.pop_front();
                if (o_result.frame_byte !== exp_res.frame_byte) begin
                    $error("frame_byte expected %02h actual %02h",
                           exp_res.frame_byte, o_result.frame_byte);
                    fail_count++;
                end
                if (o_result.last_byte !== exp_res.last_byte) begin
                    $error("last_byte expected %0b actual %0b",
                           exp_res.last_byte, o_result.last_byte);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_function_codes();
        test_back_to_back(40);
        test_drain_pause(6);
        test_random(400);

        drain_frames();
        repeat (12) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $error("%0d expected bytes never arrived", frame_q.size());
            fail_count++;
        end

        $display("%0d requests sent (%0d directed, rest random with gaps and a drain)",
                 req_count, direct_count);
        $display("%0d frame bytes checked, %0d mismatches", bytes_seen, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d bytes outstanding", frame_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
